@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the I2C transfer sequencer.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/core/i2cms_pkg.sv @@
// Package of the I2C master transfer sequencer: sizes, codes and the
// request, context and result types. No dependencies.
package i2cms_pkg;

    // Sizes
    localparam int COUNT_WIDTH          = 16;
    localparam int MAX_SUBADDRESS_BYTES = 4;

    // Transfer phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ADDR   = 3'd1;
    localparam logic [2:0] PH_SUB    = 3'd2;
    localparam logic [2:0] PH_RSTART = 3'd3;
    localparam logic [2:0] PH_WRITE  = 3'd4;
    localparam logic [2:0] PH_READ   = 3'd5;

    // Request kinds
    localparam logic REQ_TRANSFER = 1'b0;
    localparam logic REQ_BYTE_DONE = 1'b1;

    // Bus engine commands
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_SEND   = 3'd2;
    localparam logic [2:0] CMD_RSTART = 3'd3;
    localparam logic [2:0] CMD_RD_ACK = 3'd4;
    localparam logic [2:0] CMD_RD_NAK = 3'd5;
    localparam logic [2:0] CMD_STOP   = 3'd6;

    // Completion status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_ARB     = 3'd2;
    localparam logic [2:0] ST_NAK     = 3'd3;
    localparam logic [2:0] ST_ADDRNAK = 3'd4;

    // One incoming request
    typedef struct packed {
        logic        req_type;
        logic [6:0]  target_address;
        logic        read_not_write;
        logic [31:0] subaddress;
        logic [2:0]  subaddress_bytes;
        logic [15:0] data_count;
        logic        bus_busy;
        logic        in_master_mode;
        logic        got_nak;
        logic        arbitration_lost;
        logic [7:0]  received_byte;
        logic [7:0]  write_data;
    } t_item;

    // Transfer context carried from one request to the next
    typedef struct packed {
        logic [2:0]             phase;
        logic [2:0]             subaddress_left;
        logic [31:0]            held_subaddress;
        logic [COUNT_WIDTH-1:0] bytes_left;
        logic                   is_read;
        logic [6:0]             held_target;
    } t_ctx;

    // One result
    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] byte_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       restart_controller;
        logic       done_res;
        logic [2:0] status;
    } t_result;

endpackage

@@ rtl/core/i2cms_step.sv @@
// Next-context and result logic of the I2C transfer sequencer for one request.
// Depends on i2cms_pkg.
module i2cms_step (
    input  i2cms_pkg::t_item   i_item,
    input  i2cms_pkg::t_ctx    i_ctx,
    output i2cms_pkg::t_ctx    o_ctx,
    output i2cms_pkg::t_result o_res
);
    import i2cms_pkg::*;

    localparam logic [2:0] MAX_SUB = 3'(MAX_SUBADDRESS_BYTES);

    always_comb begin
        t_result                b_res;
        logic [2:0]             b_phase;
        logic [COUNT_WIDTH-1:0] b_left;
        logic [COUNT_WIDTH-1:0] dec_left;
        logic [2:0]             sub_n;
        logic [2:0]             sb;

        dec_left = i_ctx.bytes_left - COUNT_WIDTH'(1);
        sub_n    = i_ctx.subaddress_left - 3'd1;
        sb       = (i_item.subaddress_bytes > MAX_SUB) ? MAX_SUB : i_item.subaddress_bytes;

        // Start of the data phase once all address bytes went through.
        b_res   = '0;
        b_phase = i_ctx.phase;
        b_left  = i_ctx.bytes_left;
        if (i_ctx.bytes_left == '0) begin
            b_res.bus_command = CMD_STOP;
            b_res.done_res    = 1'b1;
            b_res.status      = ST_OK;
            b_phase           = PH_IDLE;
        end else if (i_ctx.is_read) begin
            b_res.bus_command = (i_ctx.bytes_left == COUNT_WIDTH'(1)) ? CMD_RD_NAK : CMD_RD_ACK;
            b_phase           = PH_READ;
        end else begin
            b_res.bus_command = CMD_SEND;
            b_res.byte_out    = i_item.write_data;
            b_left            = dec_left;
            b_phase           = PH_WRITE;
        end

        o_ctx = i_ctx;
        o_res = '0;

        if (i_item.req_type == REQ_TRANSFER) begin
            // New transfer: only taken while idle.
            if (i_ctx.phase == PH_IDLE) begin
                if (i_item.bus_busy) begin
                    o_res.done_res = 1'b1;
                    o_res.status   = ST_BUSY;
                end else begin
                    o_ctx.held_target     = i_item.target_address;
                    o_ctx.is_read         = i_item.read_not_write;
                    o_ctx.held_subaddress = i_item.subaddress;
                    o_ctx.subaddress_left = sb;
                    o_ctx.bytes_left      = COUNT_WIDTH'(i_item.data_count);
                    o_ctx.phase           = PH_ADDR;
                    o_res.bus_command     = CMD_START;
                    o_res.byte_out        = {i_item.target_address,
                                             (sb != 3'd0) ? 1'b0 : i_item.read_not_write};
                end
            end
        end else begin
            // Byte-done event from the bus engine.
            unique case (i_ctx.phase)
                PH_IDLE: begin
                end
                PH_ADDR, PH_SUB: begin
                    if (i_item.arbitration_lost) begin
                        o_res.bus_command        = CMD_STOP;
                        o_res.restart_controller = 1'b1;
                        o_res.done_res           = 1'b1;
                        o_res.status             = ST_ARB;
                        o_ctx.phase              = PH_IDLE;
                    end else if (i_item.got_nak) begin
                        o_res.bus_command = CMD_STOP;
                        o_res.done_res    = 1'b1;
                        o_res.status      = ST_NAK;
                        o_ctx.phase       = PH_IDLE;
                    end else if (i_ctx.subaddress_left != 3'd0) begin
                        o_ctx.subaddress_left = sub_n;
                        o_res.bus_command     = CMD_SEND;
                        o_res.byte_out        = i_ctx.held_subaddress[8*sub_n[1:0] +: 8];
                        o_ctx.phase           = PH_SUB;
                    end else if (i_ctx.phase == PH_SUB && i_ctx.is_read) begin
                        // Repeated start needs a free bus or mastership.
                        if (i_item.bus_busy && !i_item.in_master_mode) begin
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_BUSY;
                            o_ctx.phase    = PH_IDLE;
                        end else begin
                            o_res.bus_command = CMD_RSTART;
                            o_res.byte_out    = {i_ctx.held_target, 1'b1};
                            o_ctx.phase       = PH_RSTART;
                        end
                    end else begin
                        o_res            = b_res;
                        o_ctx.phase      = b_phase;
                        o_ctx.bytes_left = b_left;
                    end
                end
                PH_RSTART: begin
                    if (i_item.arbitration_lost || i_item.got_nak) begin
                        o_res.bus_command        = CMD_STOP;
                        o_res.restart_controller = i_item.arbitration_lost;
                        o_res.done_res           = 1'b1;
                        o_res.status             = ST_ADDRNAK;
                        o_ctx.phase              = PH_IDLE;
                    end else begin
                        o_res            = b_res;
                        o_ctx.phase      = b_phase;
                        o_ctx.bytes_left = b_left;
                    end
                end
                PH_WRITE: begin
                    if (i_item.arbitration_lost) begin
                        o_res.bus_command        = CMD_STOP;
                        o_res.restart_controller = 1'b1;
                        o_res.done_res           = 1'b1;
                        o_res.status             = ST_ARB;
                        o_ctx.phase              = PH_IDLE;
                    end else if (i_item.got_nak) begin
                        o_res.bus_command = CMD_STOP;
                        o_res.done_res    = 1'b1;
                        o_res.status      = ST_NAK;
                        o_ctx.phase       = PH_IDLE;
                    end else if (i_ctx.bytes_left != '0) begin
                        o_res.bus_command = CMD_SEND;
                        o_res.byte_out    = i_item.write_data;
                        o_ctx.bytes_left  = dec_left;
                    end else begin
                        o_res.bus_command = CMD_STOP;
                        o_res.done_res    = 1'b1;
                        o_res.status      = ST_OK;
                        o_ctx.phase       = PH_IDLE;
                    end
                end
                PH_READ: begin
                    // NAK is meaningless while reading; only arbitration matters.
                    if (i_item.arbitration_lost) begin
                        o_res.bus_command        = CMD_STOP;
                        o_res.restart_controller = 1'b1;
                        o_res.done_res           = 1'b1;
                        o_res.status             = ST_ARB;
                        o_ctx.phase              = PH_IDLE;
                    end else begin
                        o_res.read_data  = i_item.received_byte;
                        o_res.read_valid = 1'b1;
                        o_ctx.bytes_left = dec_left;
                        if (dec_left == '0) begin
                            o_res.bus_command = CMD_STOP;
                            o_res.done_res    = 1'b1;
                            o_res.status      = ST_OK;
                            o_ctx.phase       = PH_IDLE;
                        end else begin
                            o_res.bus_command = (dec_left == COUNT_WIDTH'(1)) ?
                                                CMD_RD_NAK : CMD_RD_ACK;
                        end
                    end
                end
                default: begin
                    o_ctx.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/i2c_master_transfer_sequencer.sv @@
// Top level of the I2C master transfer sequencer: input register, context,
// result register and handshakes. Depends on i2cms_pkg, i2cms_step, assert_macros.svh.
//
//  channel   direction  handshake                  accepted when
//  request   in         i_in_valid / o_in_stall    i_in_valid && !o_in_stall
//  result    out        o_out_valid / i_out_stall  o_out_valid && !i_out_stall
//
// Every request gives exactly one result. The request waits in the input register,
// then its result is registered in the result register, from which it is taken.
// A new request can be accepted every cycle unless o_in_stall is high; the context
// is updated as a request leaves the input register for the result register.
// Reset clears the pipeline valid bits and the transfer context (idle).
// A stalled result holds the result register; an occupied input register then
// holds its request and stalls the request side in the same cycle.
`include "assert_macros.svh"

module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [6:0]  i_target_address,
    input  logic        i_read_not_write,
    input  logic [31:0] i_subaddress,
    input  logic [2:0]  i_subaddress_bytes,
    input  logic [15:0] i_data_count,
    input  logic        i_bus_busy,
    input  logic        i_in_master_mode,
    input  logic        i_got_nak,
    input  logic        i_arbitration_lost,
    input  logic [7:0]  i_received_byte,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_bus_command,
    output logic [7:0]  o_byte_out,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic        o_restart_controller,
    output logic        o_done_res,
    output logic [2:0]  o_status
);
    import i2cms_pkg::*;

    logic    r_in_vld;
    t_item   r_item;
    t_ctx    r_ctx;
    t_ctx    n_ctx;
    logic    r_out_vld;
    t_result r_res;
    t_result n_res;
    logic    out_free;
    logic    advance;
    logic    res_mid;
    logic    res_restart;
    logic    res_arb_end;
    logic    res_rd_valid;
    logic    res_read_cmd;

    // Pipeline flow: the input stage moves on when the result slot frees.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= '{req_type:         i_req_type,
                        target_address:   i_target_address,
                        read_not_write:   i_read_not_write,
                        subaddress:       i_subaddress,
                        subaddress_bytes: i_subaddress_bytes,
                        data_count:       i_data_count,
                        bus_busy:         i_bus_busy,
                        in_master_mode:   i_in_master_mode,
                        got_nak:          i_got_nak,
                        arbitration_lost: i_arbitration_lost,
                        received_byte:    i_received_byte,
                        write_data:       i_write_data};
        end
    end

    // Per-request sequencing logic.
    i2cms_step u_step (
        .i_item (r_item),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    // Transfer context.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '0;
        end else if (advance) begin
            r_ctx <= n_ctx;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_bus_command        = r_res.bus_command;
    assign o_byte_out           = r_res.byte_out;
    assign o_read_data          = r_res.read_data;
    assign o_read_valid         = r_res.read_valid;
    assign o_restart_controller = r_res.restart_controller;
    assign o_done_res           = r_res.done_res;
    assign o_status             = r_res.status;

    // Terms of the checks on a shown result.
    assign res_mid      = o_out_valid && !o_done_res;
    assign res_restart  = o_out_valid && o_restart_controller;
    assign res_arb_end  = o_done_res && (o_status == ST_ARB || o_status == ST_ADDRNAK);
    assign res_rd_valid = o_out_valid && o_read_valid;
    assign res_read_cmd = (o_bus_command == CMD_STOP) || (o_bus_command == CMD_RD_ACK) ||
                          (o_bus_command == CMD_RD_NAK);

    // Checks on the sequencing and the pipeline.
    `ASSERT_IMPLIES(a_status_only_when_done, i_clk, i_rst_n, res_mid, o_status == ST_OK)
    `ASSERT_IMPLIES(a_restart_on_arb_end, i_clk, i_rst_n, res_restart, res_arb_end)
    `ASSERT_IMPLIES(a_read_data_cmd, i_clk, i_rst_n, res_rd_valid, res_read_cmd)
    `ASSERT_NEXT(a_held_request_kept, i_clk, i_rst_n, r_in_vld && !advance, r_in_vld)

endmodule
